// ----- src/hwt_pkg.sv -----
// ----------------------------------------------------------------------------
// hwt_pkg
// Shared constants, types and slot selection functions of the timing wheel.
// ----------------------------------------------------------------------------
package hwt_pkg;

  localparam int NEAR_SHIFT       = 8;
  localparam int LEVEL_SHIFT      = 6;
  localparam int NEAR_SLOTS       = 1 << NEAR_SHIFT;
  localparam int WHEEL_SLOTS      = 4 << LEVEL_SHIFT;
  localparam int POOL_ENTRIES_DEF = 64;
  localparam int TAG_BITS_DEF     = 16;
  localparam int TAG_FIELD_W      = 16;
  localparam int DELAY_W          = 31;
  localparam int KIND_W           = 2;
  localparam int SLOT_W           = 8;

  localparam logic [KIND_W-1:0] KIND_ADD_OK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_FULL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_ADD, S_ADD_FIX, S_PLACE_RD, S_PLACE_WR, S_E_START, S_E_HT,
    S_E_RD, S_E_EMIT, S_ADV, S_C_START, S_C_HT, S_C_RD, S_C_LATCH, S_C_NEXT,
    S_END, S_FLUSH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_ALLOC, OP_ALLOC_FIX, OP_PLACE_RD, OP_PLACE_WR,
    OP_WSTART, OP_WHT, OP_EMIT, OP_ADV, OP_CLATCH, OP_CNEXT, OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic near_sel;   // walk acts on the near wheel, else on the level wheels
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic full;
    logic out_free;
    logic pend_vld;
    logic slot_vld;
    logic at_tail;
    logic c_last;
  } stat_t;

  typedef struct packed {
    logic              near_sel;
    logic [SLOT_W-1:0] idx;
  } slot_t;

  // Pick the slot for an expire time t against the current time c.
  function automatic slot_t place_slot(logic [31:0] t, logic [31:0] c);
    slot_t s;
    s.near_sel = 1'b0;
    if (t[31:8] == c[31:8]) begin
      s.near_sel = 1'b1;
      s.idx      = t[7:0];
    end else if (t[31:14] == c[31:14]) begin
      s.idx = {2'd0, t[13:8]};
    end else if (t[31:20] == c[31:20]) begin
      s.idx = {2'd1, t[19:14]};
    end else if (t[31:26] == c[31:26]) begin
      s.idx = {2'd2, t[25:20]};
    end else begin
      s.idx = {2'd3, t[31:26]};
    end
    return s;
  endfunction

  // Level slot due after time moves to ct; near_sel marks that one is due.
  function automatic slot_t casc_slot(logic [31:0] ct);
    slot_t s;
    s.near_sel = 1'b1;
    s.idx      = '0;
    if (ct == '0) begin
      s.idx = {2'd3, 6'd0};
    end else if (ct[7:0] != '0) begin
      s.near_sel = 1'b0;
    end else if (ct[13:8] != '0) begin
      s.idx = {2'd0, ct[13:8]};
    end else if (ct[19:14] != '0) begin
      s.idx = {2'd1, ct[19:14]};
    end else if (ct[25:20] != '0) begin
      s.idx = {2'd2, ct[25:20]};
    end else begin
      s.idx = {2'd3, ct[31:26]};
    end
    return s;
  endfunction

endpackage

// ----- src/hwt_ram.sv -----
// ----------------------------------------------------------------------------
// hwt_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module hwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/hwt_ctrl.sv -----
// ----------------------------------------------------------------------------
// hwt_ctrl
// Sequencer of the timing wheel: add, emit, advance, cascade and flush.
// ----------------------------------------------------------------------------
module hwt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  hwt_pkg::stat_t st,
  output hwt_pkg::cmd_t  cmd
);
  import hwt_pkg::*;

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;   // second near emit of a tick
  logic   ret_r, ret_nxt;       // placement returns to the cascade walk

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= 1'b0;
      ret_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      S_IDLE:     if (in_tvalid) state_nxt = S_DISP;
      S_DISP: begin
        phase_nxt = 1'b0;
        state_nxt = st.is_tick ? S_E_START : S_ADD;
      end
      S_ADD:      state_nxt = st.full ? S_FLUSH : S_ADD_FIX;
      S_ADD_FIX: begin
        ret_nxt   = 1'b0;
        state_nxt = S_PLACE_RD;
      end
      S_PLACE_RD: state_nxt = S_PLACE_WR;
      S_PLACE_WR: state_nxt = ret_r ? S_C_NEXT : S_FLUSH;
      S_E_START: begin
        if (st.slot_vld) state_nxt = S_E_HT;
        else             state_nxt = phase_r ? S_END : S_ADV;
      end
      S_E_HT:     state_nxt = S_E_RD;
      S_E_RD:     state_nxt = S_E_EMIT;
      S_E_EMIT: begin
        if (!st.pend_vld || st.out_free) begin
          if (st.at_tail) state_nxt = phase_r ? S_END : S_ADV;
          else            state_nxt = S_E_RD;
        end
      end
      S_ADV:      state_nxt = S_C_START;
      S_C_START: begin
        if (st.slot_vld) begin
          state_nxt = S_C_HT;
        end else begin
          phase_nxt = 1'b1;
          state_nxt = S_E_START;
        end
      end
      S_C_HT:     state_nxt = S_C_RD;
      S_C_RD:     state_nxt = S_C_LATCH;
      S_C_LATCH: begin
        ret_nxt   = 1'b1;
        state_nxt = S_PLACE_RD;
      end
      S_C_NEXT: begin
        if (st.c_last) begin
          phase_nxt = 1'b1;
          state_nxt = S_E_START;
        end else begin
          state_nxt = S_C_RD;
        end
      end
      S_END:      state_nxt = st.pend_vld ? S_FLUSH : S_IDLE;
      S_FLUSH:    if (st.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = OP_NONE;
    cmd.near_sel = 1'b1;
    in_tready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = OP_LATCH;
      end
      S_ADD:      cmd.op = OP_ALLOC;
      S_ADD_FIX:  cmd.op = OP_ALLOC_FIX;
      S_PLACE_RD: cmd.op = OP_PLACE_RD;
      S_PLACE_WR: cmd.op = OP_PLACE_WR;
      S_E_START:  cmd.op = OP_WSTART;
      S_E_HT:     cmd.op = OP_WHT;
      S_E_EMIT:   if (!st.pend_vld || st.out_free) cmd.op = OP_EMIT;
      S_ADV:      cmd.op = OP_ADV;
      S_C_START: begin
        cmd.op       = OP_WSTART;
        cmd.near_sel = 1'b0;
      end
      S_C_HT: begin
        cmd.op       = OP_WHT;
        cmd.near_sel = 1'b0;
      end
      S_C_LATCH:  cmd.op = OP_CLATCH;
      S_C_NEXT:   if (!st.c_last) cmd.op = OP_CNEXT;
      S_FLUSH:    if (st.out_free) cmd.op = OP_FLUSH;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

// ----- src/hwt_dpath.sv -----
// ----------------------------------------------------------------------------
// hwt_dpath
// Time counter, free list, wheel slot memories, entry pool and result stage.
// ----------------------------------------------------------------------------
module hwt_dpath #(
  parameter int POOL_ENTRIES = hwt_pkg::POOL_ENTRIES_DEF,
  parameter int TAG_BITS     = hwt_pkg::TAG_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hwt_pkg::cmd_t                  cmd,
  output hwt_pkg::stat_t                 st,
  input  logic                           in_tuser,
  input  logic [47:0]                    in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [hwt_pkg::TAG_FIELD_W-1:0] out_tdata,
  output logic [hwt_pkg::KIND_W-1:0]     out_tuser,
  output logic                           out_tlast
);
  import hwt_pkg::*;

  localparam int PW    = $clog2(POOL_ENTRIES);
  localparam int IW    = $clog2(POOL_ENTRIES + 1);
  localparam int TAG_W = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;
  localparam logic [IW-1:0] NIL  = IW'(POOL_ENTRIES);

  // control state
  logic [31:0]           now_r, now_nxt;
  logic [IW-1:0]         fresh_r, fresh_nxt;
  logic [IW-1:0]         free_head_r, free_head_nxt;
  logic [NEAR_SLOTS-1:0] near_vld_r, near_vld_nxt;
  logic [WHEEL_SLOTS-1:0] lvl_vld_r, lvl_vld_nxt;
  logic                  casc_vld_r, casc_vld_nxt;
  logic                  pend_vld_r, pend_vld_nxt;
  logic                  out_vld_r, out_vld_nxt;
  // payload
  logic [PW-1:0]         cur_r, cur_nxt;
  logic [PW-1:0]         tail_r, tail_nxt;
  logic [PW-1:0]         nx_r, nx_nxt;
  logic                  last_r, last_nxt;
  logic [31:0]           exp_r, exp_nxt;
  logic [DELAY_W-1:0]    delay_r, delay_nxt;
  logic [TAG_W-1:0]      tag_r, tag_nxt;
  logic                  is_tick_r, is_tick_nxt;
  logic                  recyc_r, recyc_nxt;
  slot_t                 tgt_r, tgt_nxt;
  logic [SLOT_W-1:0]     casc_idx_r, casc_idx_nxt;
  logic [KIND_W-1:0]     pend_kind_r, pend_kind_nxt;
  logic [TAG_FIELD_W-1:0] pend_tag_r, pend_tag_nxt;
  logic [KIND_W-1:0]     out_kind_r, out_kind_nxt;
  logic [TAG_FIELD_W-1:0] out_tag_r, out_tag_nxt;
  logic                  out_last_r, out_last_nxt;

  // memory ports
  logic              near_we, lvl_we, nxt_we, exp_we;
  logic [SLOT_W-1:0] near_raddr, lvl_raddr, slot_waddr;
  logic [2*PW-1:0]   slot_wdata, near_rd, lvl_rd, wheel_rd;
  logic [PW-1:0]     nxt_waddr, nxt_raddr;
  logic [IW-1:0]     nxt_wdata, nxt_rd;
  logic [31:0]       exp_rd;
  logic [TAG_W-1:0]  tag_rd;

  logic              full;
  logic              out_free;
  logic              tgt_vld;
  logic [31:0]       now_inc;
  slot_t             pl;
  slot_t             cs;

  // head and tail of the target slot as read during placement
  function automatic logic [PW-1:0] wheel_rd_tgt_head();
    return tgt_r.near_sel ? near_rd[2*PW-1:PW] : lvl_rd[2*PW-1:PW];
  endfunction

  function automatic logic [PW-1:0] tgt_tail();
    return tgt_r.near_sel ? near_rd[PW-1:0] : lvl_rd[PW-1:0];
  endfunction

  assign full     = (free_head_r == NIL) && (fresh_r == NIL);
  assign out_free = !out_vld_r || out_tready;
  assign pl       = place_slot(exp_r, now_r);
  assign now_inc  = now_r + 32'd1;
  assign cs       = casc_slot(now_inc);
  assign wheel_rd = cmd.near_sel ? near_rd : lvl_rd;
  assign tgt_vld  = tgt_r.near_sel ? near_vld_r[tgt_r.idx] : lvl_vld_r[tgt_r.idx];

  assign near_raddr = (cmd.op == OP_PLACE_RD) ? pl.idx : now_r[SLOT_W-1:0];
  assign lvl_raddr  = (cmd.op == OP_PLACE_RD) ? pl.idx : casc_idx_r;
  assign nxt_raddr  = (cmd.op == OP_ALLOC) ? free_head_r[PW-1:0] : cur_r;

  always_comb begin
    now_nxt       = now_r;
    fresh_nxt     = fresh_r;
    free_head_nxt = free_head_r;
    near_vld_nxt  = near_vld_r;
    lvl_vld_nxt   = lvl_vld_r;
    casc_vld_nxt  = casc_vld_r;
    pend_vld_nxt  = pend_vld_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    cur_nxt       = cur_r;
    tail_nxt      = tail_r;
    nx_nxt        = nx_r;
    last_nxt      = last_r;
    exp_nxt       = exp_r;
    delay_nxt     = delay_r;
    tag_nxt       = tag_r;
    is_tick_nxt   = is_tick_r;
    recyc_nxt     = recyc_r;
    tgt_nxt       = tgt_r;
    casc_idx_nxt  = casc_idx_r;
    pend_kind_nxt = pend_kind_r;
    pend_tag_nxt  = pend_tag_r;
    out_kind_nxt  = out_kind_r;
    out_tag_nxt   = out_tag_r;
    out_last_nxt  = out_last_r;
    near_we       = 1'b0;
    lvl_we        = 1'b0;
    nxt_we        = 1'b0;
    exp_we        = 1'b0;
    slot_waddr    = tgt_r.idx;
    slot_wdata    = {cur_r, cur_r};
    nxt_waddr     = cur_r;
    nxt_wdata     = free_head_r;

    case (cmd.op)
      OP_LATCH: begin
        is_tick_nxt = in_tuser;
        delay_nxt   = in_tdata[DELAY_W-1:0];
        tag_nxt     = in_tdata[DELAY_W +: TAG_W];
      end
      OP_ALLOC: begin
        pend_vld_nxt = 1'b1;
        pend_tag_nxt = TAG_FIELD_W'(tag_r);
        if (full) begin
          pend_kind_nxt = KIND_ADD_FULL;
        end else begin
          pend_kind_nxt = KIND_ADD_OK;
          recyc_nxt     = (free_head_r != NIL);
          // recycled entries sit above the never used ones
          if (free_head_r != NIL) begin
            cur_nxt = free_head_r[PW-1:0];
          end else begin
            cur_nxt   = fresh_r[PW-1:0];
            fresh_nxt = fresh_r + IW'(1);
          end
          exp_nxt = now_r + 32'(delay_r);
          exp_we  = 1'b1;
        end
      end
      OP_ALLOC_FIX: if (recyc_r) free_head_nxt = nxt_rd;
      OP_PLACE_RD:  tgt_nxt = pl;
      OP_PLACE_WR: begin
        // append at the tail, or open the slot
        if (tgt_vld) begin
          slot_wdata = {wheel_rd_tgt_head(), cur_r};
          nxt_we     = 1'b1;
          nxt_waddr  = tgt_tail();
          nxt_wdata  = IW'(cur_r);
        end
        if (tgt_r.near_sel) begin
          near_we                 = 1'b1;
          near_vld_nxt[tgt_r.idx] = 1'b1;
        end else begin
          lvl_we                 = 1'b1;
          lvl_vld_nxt[tgt_r.idx] = 1'b1;
        end
      end
      OP_WSTART: begin
        if (cmd.near_sel) near_vld_nxt[now_r[SLOT_W-1:0]] = 1'b0;
        else if (casc_vld_r) lvl_vld_nxt[casc_idx_r] = 1'b0;
      end
      OP_WHT: begin
        cur_nxt  = wheel_rd[2*PW-1:PW];
        tail_nxt = wheel_rd[PW-1:0];
      end
      OP_EMIT: begin
        if (pend_vld_r) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = pend_kind_r;
          out_tag_nxt  = pend_tag_r;
          out_last_nxt = 1'b0;
        end
        pend_vld_nxt  = 1'b1;
        pend_kind_nxt = KIND_EXPIRED;
        pend_tag_nxt  = TAG_FIELD_W'(tag_rd);
        // push the entry back on the free list
        nxt_we        = 1'b1;
        free_head_nxt = IW'(cur_r);
        cur_nxt       = nxt_rd[PW-1:0];
      end
      OP_ADV: begin
        now_nxt      = now_inc;
        casc_vld_nxt = cs.near_sel;
        casc_idx_nxt = cs.idx;
      end
      OP_CLATCH: begin
        nx_nxt   = nxt_rd[PW-1:0];
        last_nxt = (cur_r == tail_r);
        exp_nxt  = exp_rd;
      end
      OP_CNEXT: cur_nxt = nx_r;
      OP_FLUSH: begin
        out_vld_nxt  = 1'b1;
        out_kind_nxt = pend_kind_r;
        out_tag_nxt  = pend_tag_r;
        out_last_nxt = 1'b1;
        pend_vld_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      fresh_r     <= '0;
      free_head_r <= NIL;
      near_vld_r  <= '0;
      lvl_vld_r   <= '0;
      casc_vld_r  <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      now_r       <= now_nxt;
      fresh_r     <= fresh_nxt;
      free_head_r <= free_head_nxt;
      near_vld_r  <= near_vld_nxt;
      lvl_vld_r   <= lvl_vld_nxt;
      casc_vld_r  <= casc_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    tail_r      <= tail_nxt;
    nx_r        <= nx_nxt;
    last_r      <= last_nxt;
    exp_r       <= exp_nxt;
    delay_r     <= delay_nxt;
    tag_r       <= tag_nxt;
    is_tick_r   <= is_tick_nxt;
    recyc_r     <= recyc_nxt;
    tgt_r       <= tgt_nxt;
    casc_idx_r  <= casc_idx_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_tag_r  <= pend_tag_nxt;
    out_kind_r  <= out_kind_nxt;
    out_tag_r   <= out_tag_nxt;
    out_last_r  <= out_last_nxt;
  end

  hwt_ram #(.WIDTH(2*PW), .DEPTH(NEAR_SLOTS)) u_near_ram (
    .clk(clk), .we(near_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(near_raddr), .rdata(near_rd)
  );

  hwt_ram #(.WIDTH(2*PW), .DEPTH(WHEEL_SLOTS)) u_lvl_ram (
    .clk(clk), .we(lvl_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(lvl_raddr), .rdata(lvl_rd)
  );

  hwt_ram #(.WIDTH(IW), .DEPTH(POOL_ENTRIES)) u_next_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(nxt_raddr), .rdata(nxt_rd)
  );

  hwt_ram #(.WIDTH(32), .DEPTH(POOL_ENTRIES)) u_exp_ram (
    .clk(clk), .we(exp_we), .waddr(cur_nxt), .wdata(exp_nxt),
    .raddr(cur_r), .rdata(exp_rd)
  );

  hwt_ram #(.WIDTH(TAG_W), .DEPTH(POOL_ENTRIES)) u_tag_ram (
    .clk(clk), .we(exp_we), .waddr(cur_nxt), .wdata(tag_r),
    .raddr(cur_r), .rdata(tag_rd)
  );

  always_comb begin
    st.is_tick  = is_tick_r;
    st.full     = full;
    st.out_free = out_free;
    st.pend_vld = pend_vld_r;
    st.slot_vld = cmd.near_sel ? near_vld_r[now_r[SLOT_W-1:0]]
                               : (casc_vld_r && lvl_vld_r[casc_idx_r]);
    st.at_tail  = (cur_r == tail_r);
    st.c_last   = last_r;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_tag_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- src/hierarchical_timer_wheel_core.sv -----
// Throughput: one item at a time; the next item is taken once the last result
// of the current one, if it has any, sits in the output register.
// Reset: synchronous, active low; time is zero, all slots empty, pool free.
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_core
// Five level timing wheel: a 256 slot near wheel and four 64 slot level
// wheels over a 32-bit tick count, with entries taken from a fixed pool.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_core #(
  parameter int POOL_ENTRIES = hwt_pkg::POOL_ENTRIES_DEF,
  parameter int TAG_BITS     = hwt_pkg::TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // delay[30:0], tag[46:31], zero[47]
  input  logic        in_tuser,    // cmd: add or tick
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // tag[15:0] of the added or expired entry
  output logic [1:0]  out_tuser,   // kind
  output logic        out_tlast    // last result of the item
);
  import hwt_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // The controller walks one slot list at a time; the datapath holds time,
  // the free list (recycled entries above a fill count of unused ones), the
  // slot valid bits and the memories. One result is held back so that the
  // last flag can be set once the tick has nothing more to emit.
  hwt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .st(st), .cmd(cmd)
  );

  hwt_dpath #(.POOL_ENTRIES(POOL_ENTRIES), .TAG_BITS(TAG_BITS)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

endmodule
